// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, command codes and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths of the stream payloads.
    localparam int MODE_W      = 3;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int POS_W       = 11;
    localparam int LINE_W      = 5;
    localparam int CELL_W      = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    // Command codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_PUT_CUR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUT_POS  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_CUR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLR_LINE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCROLL   = 3'd5;

    typedef enum logic [2:0] {
        K_PUT_CUR,
        K_PUT_POS,
        K_SET_CUR,
        K_CLEAR,
        K_CLR_LINE,
        K_SCROLL,
        K_NOP
    } t_kind;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_kind             kind;
        logic [CELL_W-1:0] cell_val;
        logic [POS_W-1:0]  pos;
        logic              pos_ok;
        logic [LINE_W-1:0] line;
        logic              line_ok;
        logic [POS_W-1:0]  cur_set;
    } t_cmd;

    typedef struct packed {
        logic [CELL_W-1:0] cell_word;
        logic              scrolled;
        logic [POS_W-1:0]  cursor_position;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_RESP,
        ST_FILL,
        ST_COPY,
        ST_COPY_END
    } t_state;

endpackage

`default_nettype wire

// ----- src/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transactions, decodes the mode and checks ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_enable,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                                 o_cmd_valid,
    input  wire logic                            i_cmd_ready,
    output tcw_pkg::t_cmd                        o_cmd
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [LINE_W-1:0] line;

    assign mode = i_s_tdata[2:0];
    assign pos  = i_s_tdata[29:19];
    assign line = i_s_tdata[34:30];

    assign o_s_tready  = i_enable && (!r_valid || i_cmd_ready);
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        unique case (mode)
            MODE_PUT_CUR:  n_cmd.kind = K_PUT_CUR;
            MODE_PUT_POS:  n_cmd.kind = K_PUT_POS;
            MODE_SET_CUR:  n_cmd.kind = K_SET_CUR;
            MODE_CLEAR:    n_cmd.kind = K_CLEAR;
            MODE_CLR_LINE: n_cmd.kind = K_CLR_LINE;
            MODE_SCROLL:   n_cmd.kind = K_SCROLL;
            default:       n_cmd.kind = K_NOP;
        endcase
        // Cell word is background, foreground, character from the top down.
        n_cmd.cell_val = {i_s_tdata[18:15], i_s_tdata[14:11], i_s_tdata[10:3]};
        n_cmd.pos      = pos;
        n_cmd.pos_ok   = {21'd0, pos} < 32'(CELL_COUNT);
        n_cmd.line     = line;
        n_cmd.line_ok  = {27'd0, line} < 32'(ROWS);
        // A new cursor beyond the end of the screen saturates to the end.
        n_cmd.cur_set  = ({21'd0, pos} > 32'(CELL_COUNT)) ? POS_W'(CELL_COUNT) : pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tcw_pkg::t_cmd i_push_cmd,
    output logic               o_not_full,
    input  wire logic          i_pop,
    output logic               o_not_empty,
    output tcw_pkg::t_cmd      o_head
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_not_full  = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_slots[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen memory and the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    output logic               o_init_busy,
    input  wire logic          i_cmd_valid,
    input  wire tcw_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output tcw_pkg::t_result   o_res
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + 1);
    localparam int COPY_LAST  = CELL_COUNT - COLUMNS - 1;
    localparam int LAST_ROW   = CELL_COUNT - COLUMNS;

    logic [CELL_W-1:0] r_screen [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state,    n_state;
    t_cmd              r_cmd,      n_cmd;
    logic [AW-1:0]     r_cnt,      n_cnt;
    logic [AW-1:0]     r_fill_end, n_fill_end;
    logic [CELL_W-1:0] r_fill_val, n_fill_val;
    logic [CW-1:0]     r_cursor,   n_cursor;
    logic              r_scrolled, n_scrolled;
    logic              r_init,     n_init;
    logic              r_cp_pend,  n_cp_pend;
    logic [AW-1:0]     r_cp_dst,   n_cp_dst;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,      n_out;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     line_base;
    logic [AW-1:0]     line_end;

    assign o_init_busy = r_init;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign line_base = AW'(32'(i_cmd.line) * COLUMNS);
    assign line_end  = AW'(32'(i_cmd.line) * COLUMNS + COLUMNS - 1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_fill_end  = r_fill_end;
        n_fill_val  = r_fill_val;
        n_cursor    = r_cursor;
        n_scrolled  = r_scrolled;
        n_init      = r_init;
        n_cp_pend   = 1'b0;
        n_cp_dst    = r_cp_dst;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = AW'(r_cmd.pos);
        // A copy write left over from the scroll sweep owns the write port.
        wr_en       = r_cp_pend;
        wr_addr     = r_cp_dst;
        wr_data     = r_rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_scrolled = 1'b0;
                    n_state    = ST_READ;
                    case (i_cmd.kind)
                        K_PUT_CUR: begin
                            if (32'(r_cursor) >= 32'(CELL_COUNT)) begin
                                n_cnt   = '0;
                                n_state = ST_COPY;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        K_PUT_POS: begin
                            if (i_cmd.pos_ok) begin
                                n_state = ST_PUT;
                            end
                        end
                        K_SET_CUR: begin
                            n_cursor = CW'(i_cmd.cur_set);
                        end
                        K_CLEAR: begin
                            n_cursor   = '0;
                            n_cnt      = '0;
                            n_fill_end = AW'(CELL_COUNT - 1);
                            n_fill_val = BLANK_CELL;
                            n_state    = ST_FILL;
                        end
                        K_CLR_LINE: begin
                            if (i_cmd.line_ok) begin
                                n_cnt      = line_base;
                                n_fill_end = line_end;
                                n_fill_val = '0;
                                n_state    = ST_FILL;
                            end
                        end
                        K_SCROLL: begin
                            n_cnt   = '0;
                            n_state = ST_COPY;
                        end
                        default: begin
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                wr_en   = 1'b1;
                wr_data = r_cmd.cell_val;
                if (r_cmd.kind == K_PUT_CUR) begin
                    wr_addr  = AW'(r_cursor);
                    n_cursor = r_cursor + 1'b1;
                end else begin
                    wr_addr = AW'(r_cmd.pos);
                end
                n_state = ST_READ;
            end
            ST_READ: begin
                rd_en   = r_cmd.pos_ok;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.cursor_position = POS_W'(r_cursor);
                    n_out.scrolled        = r_scrolled;
                    n_out.cell_word       = r_cmd.pos_ok ? r_rd_data : '0;
                    n_state               = ST_IDLE;
                end
            end
            ST_COPY: begin
                // Read the cell one row below; its write lands in the next cycle.
                rd_en     = 1'b1;
                rd_addr   = AW'(32'(r_cnt) + COLUMNS);
                n_cp_pend = 1'b1;
                n_cp_dst  = r_cnt;
                if (r_cnt == AW'(COPY_LAST)) begin
                    n_state = ST_COPY_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_COPY_END: begin
                n_scrolled = 1'b1;
                n_cnt      = AW'(LAST_ROW);
                n_fill_end = AW'(CELL_COUNT - 1);
                n_fill_val = '0;
                n_state    = ST_FILL;
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = r_fill_val;
                if (r_cnt == r_fill_end) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = ST_IDLE;
                    end else if (r_scrolled) begin
                        n_cursor = (32'(r_cursor) >= 32'(COLUMNS))
                                 ? CW'(32'(r_cursor) - 32'(COLUMNS)) : '0;
                        n_state  = (r_cmd.kind == K_PUT_CUR) ? ST_PUT : ST_READ;
                    end else begin
                        n_state = ST_READ;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Reset starts the clearing pass over the whole screen.
            r_state     <= ST_FILL;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_fill_end  <= AW'(CELL_COUNT - 1);
            r_fill_val  <= BLANK_CELL;
            r_cursor    <= '0;
            r_scrolled  <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_cnt       <= n_cnt;
            r_fill_end  <= n_fill_end;
            r_fill_val  <= n_fill_val;
            r_cursor    <= n_cursor;
            r_scrolled  <= n_scrolled;
            r_cp_pend   <= n_cp_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cp_dst <= n_cp_dst;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_screen[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_screen[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen memory, cursor and command execution.
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream (i_s_*), one per transaction, and each
// one returns exactly one result transaction on the master stream (o_m_*).
// A front stage decodes the mode and range-checks position and line, a
// two-entry queue holds decoded commands, and the back sequencer executes
// them on a screen memory of COLUMNS*ROWS cells with one read port and
// one write port. The back takes a put that writes a cell through pop,
// write, read and respond, and other single-cell commands through pop,
// read and respond; clear screen, clear line and scroll take longer, since
// every cell they touch passes through the one memory write port.
// After reset the back clears all COLUMNS*ROWS cells to blank, one per
// cycle, while o_s_tready stays low.
// A stalled result waits in the output register; the back, the queue and
// the front stage take up to four further commands before o_s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // mode[2:0], character[10:3], foreground[14:11], background[18:15],
    // position[29:19], line[34:30], zero padding[39:35]
    input  wire logic [tcw_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // cursor_position[10:0], scrolled[11], cell_word[27:12], zero padding[31:28]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]       o_m_tdata
);
    import tcw_pkg::*;

    logic    init_busy;
    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_not_full;
    logic    q_not_empty;
    t_cmd    q_head;
    logic    q_pop;
    t_result result;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (!init_busy),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_not_full),
        .o_cmd       (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_cmd  (front_cmd),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_busy (init_busy),
        .i_cmd_valid (q_not_empty),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (result)
    );

    assign o_m_tdata = {4'd0, result.cell_word, result.scrolled, result.cursor_position};

endmodule

`default_nettype wire

// ----- src/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_port_checks
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_port_checks #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             o_s_tready,
    input  wire logic [tcw_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [tcw_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or vanished while stalled");

    // Reset drops any pending result.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // The screen clearing pass after reset blocks new commands.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("command accepted during the clearing pass");

    // The reported cursor never leaves the screen plus one.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> {21'd0, o_m_tdata[10:0]} <= 32'(CELL_COUNT))
        else $error("cursor beyond the end of the screen");

    // After a scroll the cursor is at most CELL_COUNT - COLUMNS + 1.
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[11]
        |-> {21'd0, o_m_tdata[10:0]} <= 32'(CELL_COUNT - COLUMNS + 1))
        else $error("cursor not moved up by a scroll");

endmodule

bind text_console_writer tcw_port_checks #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ----- tb/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// Watches both streams of the text console writer and checks every result.
// ----------------------------------------------------------------------------
// Each accepted command is applied to a local copy of the screen and cursor.
// The result that command should return is queued. Each accepted result is
// compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    // mode[2:0], character[10:3], foreground[14:11], background[18:15],
    // position[29:19], line[34:30], zero padding[39:35]
    input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    // cursor_position[10:0], scrolled[11], cell_word[27:12], zero padding[31:28]
    input  wire logic [tcw_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import tcw_pkg::*;

    localparam int CELLS = DEF_COLUMNS * DEF_ROWS;

    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cursor;
    t_result           console_results [$];
    t_result           oldest;
    int                fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic scroll_screen();
        for (int k = 0; k + DEF_COLUMNS < CELLS; k++) begin
            screen[k] = screen[k + DEF_COLUMNS];
        end
        for (int k = CELLS - DEF_COLUMNS; k < CELLS; k++) begin
            screen[k] = '0;
        end
        cursor = (cursor >= DEF_COLUMNS) ? cursor - DEF_COLUMNS : 0;
    endtask

    // Applies one command to the screen copy and queues the result it returns.
    task automatic execute_command(input logic [IN_TDATA_W-1:0] cmd);
        logic [MODE_W-1:0] mode;
        logic [CELL_W-1:0] cell_val;
        int unsigned       pos;
        int unsigned       row;
        logic              scrolled;
        t_result           res;
        mode     = cmd[2:0];
        cell_val = {cmd[18:15], cmd[14:11], cmd[10:3]};
        pos      = cmd[29:19];
        row      = cmd[34:30];
        scrolled = 1'b0;
        case (mode)
            MODE_PUT_CUR: begin
                // A cursor past the last cell scrolls before the write.
                if (cursor >= CELLS) begin
                    scroll_screen();
                    scrolled = 1'b1;
                end
                if (cursor < CELLS) begin
                    screen[cursor] = cell_val;
                    cursor         = cursor + 1;
                end
            end
            MODE_PUT_POS: begin
                if (pos < CELLS) begin
                    screen[pos] = cell_val;
                end
            end
            MODE_SET_CUR: begin
                cursor = (pos > CELLS) ? CELLS : pos;
            end
            MODE_CLEAR: begin
                for (int k = 0; k < CELLS; k++) begin
                    screen[k] = BLANK_CELL;
                end
                cursor = 0;
            end
            MODE_CLR_LINE: begin
                if (row < DEF_ROWS) begin
                    for (int k = 0; k < DEF_COLUMNS; k++) begin
                        screen[row * DEF_COLUMNS + k] = '0;
                    end
                end
            end
            MODE_SCROLL: begin
                scroll_screen();
                scrolled = 1'b1;
            end
            default: begin
            end
        endcase
        res.cursor_position = POS_W'(cursor);
        res.scrolled        = scrolled;
        res.cell_word       = (pos < CELLS) ? screen[pos] : '0;
        console_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                screen[k] = BLANK_CELL;
            end
            cursor = 0;
            console_results.delete();
        end else begin
            // Results are checked before new commands are queued, so a result
            // that shows up without any command ahead of it is caught.
            if (i_m_tvalid && i_m_tready) begin
                if (console_results.size() == 0) begin
                    $error("result transaction with no command pending: tdata %h",
                           i_m_tdata);
                    fail_count++;
                end else begin
                    oldest = console_results.pop_front();
                    if (i_m_tdata[10:0] !== oldest.cursor_position) begin
                        $error("cursor_position mismatch: expected %0d, actual %0d",
                               oldest.cursor_position, i_m_tdata[10:0]);
                        fail_count++;
                    end
                    if (i_m_tdata[11] !== oldest.scrolled) begin
                        $error("scrolled mismatch: expected %0d, actual %0d",
                               oldest.scrolled, i_m_tdata[11]);
                        fail_count++;
                    end
                    if (i_m_tdata[27:12] !== oldest.cell_word) begin
                        $error("cell_word mismatch: expected %h, actual %h",
                               oldest.cell_word, i_m_tdata[27:12]);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                execute_command(i_s_tdata);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= console_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the text console writer.
// ----------------------------------------------------------------------------
// A directed sequence hits the screen edges, cursor saturation, the scroll
// on a put past the last cell, out-of-range lines and positions and the
// spare modes. Random commands follow, weighted toward character puts with
// the cursor often parked near the end of the screen. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import tcw_pkg::*;

    localparam int CELLS        = DEF_COLUMNS * DEF_ROWS;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int LINE_MAX     = (1 << LINE_W) - 1;
    localparam int RANDOM_ITEMS = 1525;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 16_000_000;

    // Modes with no command behind them.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int mode_count [8];
    int aim         = 0;  // cursor as the stimulus tracks it, to aim queries
    bit send_quiet  = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    text_console_writer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    tcw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one command after a random gap and returns once it is taken.
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input int ch, input int fg,
                            input int bg, input int pos, input int row);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= IN_TDATA_W'({$urandom(), $urandom()});
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, row[4:0], pos[10:0], bg[3:0], fg[3:0], ch[7:0], mode};
        do @(posedge i_clk); while (!o_s_tready);
        mode_count[mode]++;
        case (mode)
            MODE_PUT_CUR: aim = ((aim >= CELLS) ? aim - DEF_COLUMNS : aim) + 1;
            MODE_SET_CUR: aim = (pos > CELLS) ? CELLS : pos;
            MODE_CLEAR:   aim = 0;
            MODE_SCROLL:  aim = (aim >= DEF_COLUMNS) ? aim - DEF_COLUMNS : 0;
            default: begin
            end
        endcase
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial begin
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 100 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
        end
    end

    initial begin
        int ch;
        int fg;
        int bg;
        int pos;
        int row;
        int pick;
        int any_pos;
        int near;
        foreach (mode_count[m]) mode_count[m] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands.
        send_cmd(MODE_PUT_POS,  255, 15, 15, 0, 0);
        send_cmd(MODE_PUT_POS,  0, 0, 0, CELLS - 1, LINE_MAX);
        send_cmd(MODE_PUT_POS,  'h41, 7, 1, CELLS, 0);
        send_cmd(MODE_PUT_POS,  'h42, 2, 3, POS_MAX, 0);
        send_cmd(MODE_PUT_CUR,  'h48, 10, 5, 0, 0);
        send_cmd(MODE_SET_CUR,  0, 0, 0, CELLS - 2, 0);
        send_cmd(MODE_PUT_CUR,  'h80, 12, 4, CELLS - 2, 0);
        send_cmd(MODE_PUT_CUR,  'h7F, 3, 12, CELLS - 1, 0);
        // The cursor now sits past the last cell: this put scrolls first.
        send_cmd(MODE_PUT_CUR,  'h5A, 9, 6, CELLS - DEF_COLUMNS, 0);
        send_cmd(MODE_SET_CUR,  0, 0, 0, POS_MAX, 0);
        send_cmd(MODE_SET_CUR,  0, 0, 0, CELLS, 0);
        send_cmd(MODE_SCROLL,   0, 0, 0, CELLS - 2 * DEF_COLUMNS, 0);
        send_cmd(MODE_SET_CUR,  0, 0, 0, DEF_COLUMNS / 2, 0);
        send_cmd(MODE_SCROLL,   0, 0, 0, 0, 0);
        send_cmd(MODE_CLR_LINE, 0, 0, 0, 5, 0);
        send_cmd(MODE_CLR_LINE, 0, 0, 0, CELLS - 1, DEF_ROWS - 1);
        send_cmd(MODE_CLR_LINE, 0, 0, 0, 1000, DEF_ROWS);
        send_cmd(MODE_CLR_LINE, 0, 0, 0, 0, LINE_MAX);
        send_cmd(MODE_SPARE_A,  'hAA, 5, 10, 0, 3);
        send_cmd(MODE_SPARE_B,  'h55, 10, 5, CELLS - 1, 7);
        send_cmd(MODE_CLEAR,    0, 0, 0, 1500, 0);
        send_cmd(MODE_PUT_CUR,  'h31, 14, 1, 0, 0);
        send_cmd(MODE_SET_CUR,  0, 0, 0, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            ch      = $urandom_range(0, 255);
            fg      = $urandom_range(0, 15);
            bg      = $urandom_range(0, 15);
            row     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, LINE_MAX)
                                                   : $urandom_range(0, DEF_ROWS - 1);
            any_pos = $urandom_range(0, POS_MAX);
            // The cell that a put at the cursor is about to write.
            near    = (aim >= CELLS) ? aim - DEF_COLUMNS : aim;
            pick    = $urandom_range(0, 99);
            if (pick < 45 || pick >= 94) begin
                pos = ($urandom_range(0, 2) != 0) ? near : any_pos;
                send_cmd(MODE_PUT_CUR, ch, fg, bg, pos, row);
            end else if (pick < 65) begin
                pos = ($urandom_range(0, 9) == 0) ? $urandom_range(CELLS, POS_MAX)
                                                   : $urandom_range(0, CELLS - 1);
                send_cmd(MODE_PUT_POS, ch, fg, bg, pos, row);
            end else if (pick < 77) begin
                case ($urandom_range(0, 5))
                    0, 1:    pos = $urandom_range(CELLS - 10, CELLS);
                    2:       pos = $urandom_range(CELLS, POS_MAX);
                    3:       pos = $urandom_range(0, DEF_COLUMNS - 1);
                    default: pos = $urandom_range(0, CELLS);
                endcase
                send_cmd(MODE_SET_CUR, ch, fg, bg, pos, row);
            end else if (pick < 85) begin
                send_cmd(MODE_CLR_LINE, ch, fg, bg, any_pos, row);
            end else if (pick < 89) begin
                send_cmd(MODE_SCROLL, ch, fg, bg, any_pos, row);
            end else if (pick < 91) begin
                send_cmd(MODE_CLEAR, ch, fg, bg, any_pos, row);
            end else begin
                send_cmd($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B,
                         ch, fg, bg, any_pos, row);
            end
        end
        i_s_tvalid <= 1'b0;

        // Let the count of outstanding results take in the last command.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d commands: %0d puts at cursor, %0d puts at position,",
                 RANDOM_ITEMS + 23, mode_count[MODE_PUT_CUR], mode_count[MODE_PUT_POS]);
        $display("%0d cursor sets, %0d screen clears, %0d line clears, %0d scrolls,",
                 mode_count[MODE_SET_CUR], mode_count[MODE_CLEAR],
                 mode_count[MODE_CLR_LINE], mode_count[MODE_SCROLL]);
        $display("%0d spare modes; one %0d-cycle hold-off on the result side.",
                 mode_count[MODE_SPARE_A] + mode_count[MODE_SPARE_B], HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
